// ----- rtl/kth_smallest_max_heap_select_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the k-th smallest selection block.
// Each macro states a clocked property that an active-low reset disables.
// ---------------------------------------------------------------------------
`ifndef KTH_SMALLEST_MAX_HEAP_SELECT_CORE_ASSERT_SVH
`define KTH_SMALLEST_MAX_HEAP_SELECT_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define KTHSEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define KTHSEL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/kthsel_pkg.sv -----
// ---------------------------------------------------------------------------
// kthsel_pkg
// Shared constants and controller/datapath signal groups.
// ---------------------------------------------------------------------------
package kthsel_pkg;

  localparam int K_MAX  = 64;
  localparam int DATA_W = 32;
  localparam int AW     = $clog2(K_MAX);
  localparam int CNT_W  = $clog2(K_MAX + 1);
  localparam int RANK_W = 7;

  localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take the input item
    logic rd_up;    // read the parent of the current position
    logic step_up;  // move the parent down into the hole
    logic step_dn;  // move the chosen child up into the hole
    logic wr_key;   // write the key into the hole
    logic out_load; // load the result register and clear the fill count
  } kthsel_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic insert_ok;  // heap is not yet full for the current rank
    logic fill_zero;  // heap is empty
    logic replace_ok; // incoming value is below the heap top
    logic up_move;    // key is above its parent
    logic up_top;     // parent is the root
    logic dn_leaf;    // current position has no child
    logic dn_move;    // a child is above the key
    logic last;       // item in progress closes the set
    logic out_free;   // result register can take a new result
  } kthsel_sts_t;

endpackage

// ----- rtl/kthsel_in_if.sv -----
// ---------------------------------------------------------------------------
// kthsel_in_if
// Input channel: one data value per item with an end-of-set marker.
// ---------------------------------------------------------------------------
interface kthsel_in_if;
  import kthsel_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/kthsel_out_if.sv -----
// ---------------------------------------------------------------------------
// kthsel_out_if
// Result channel: the k-th smallest value and the short-set flag.
// ---------------------------------------------------------------------------
interface kthsel_out_if;
  import kthsel_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] kth_value;
  logic                     short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

// ----- rtl/kth_smallest_max_heap_select_core.sv -----
// ---------------------------------------------------------------------------
// kth_smallest_max_heap_select_core
// Keeps a max-heap of the k smallest values of a set and gives its top,
// the k-th smallest value, on the item that closes the set.
// ---------------------------------------------------------------------------
//   Channel  Direction  Handshake        Payload
//   in_ch    in         valid / ready    value (s32), last
//   out_ch   out        valid / ready    kth_value (s32), short_set
//   cfg      in         cfg_we           cfg_wdata (rank_k, 7 bits)
//
// An item passes straight from idle to finish when the heap is left unchanged;
// a sift-up or a sift-down walks up to all six levels. Each level costs one
// heap RAM read and one compare-and-move, a sift-down spends one more read on
// finding the leaf, and the RAM write port writes the key last. The block takes
// one item at a time; in_ch.ready is high only when idle.
// A finished result waits in the output register while the next item is taken;
// the block stalls only when a new result meets a result still unaccepted.
// Reset is synchronous and clears the fill count, sets rank_k to 1 and needs
// no clearing pass over the heap RAM.
// ---------------------------------------------------------------------------
module kth_smallest_max_heap_select_core (
  input  logic                          clk,
  input  logic                          rst_n,
  kthsel_in_if.sink                     in_ch,
  kthsel_out_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [kthsel_pkg::RANK_W-1:0] cfg_wdata
);
  import kthsel_pkg::*;

  kthsel_cmd_t cmd;
  kthsel_sts_t sts;

  // Sequencer.
  kthsel_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Heap storage and arithmetic.
  kthsel_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_ch.value),
    .in_last       (in_ch.last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kth_value (out_ch.kth_value),
    .out_short_set (out_ch.short_set)
  );

endmodule

// ----- rtl/kthsel_ram.sv -----
// ---------------------------------------------------------------------------
// kthsel_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module kthsel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- rtl/kthsel_ctrl.sv -----
// ---------------------------------------------------------------------------
// kthsel_ctrl
// Controller: steps one item through insert, sift-up, sift-down and result.
// ---------------------------------------------------------------------------
module kthsel_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  kthsel_pkg::kthsel_sts_t sts,
  output kthsel_pkg::kthsel_cmd_t cmd
);
  import kthsel_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_UP_RD  = 7'b0000010,
    ST_UP_CMP = 7'b0000100,
    ST_DN_RD  = 7'b0001000,
    ST_DN_CMP = 7'b0010000,
    ST_WR     = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.insert_ok) begin
            state_nxt = sts.fill_zero ? ST_WR : ST_UP_RD;
          end else if (sts.replace_ok) begin
            state_nxt = ST_DN_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_UP_RD: begin
        cmd.rd_up = 1'b1;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (sts.up_move) begin
          cmd.step_up = 1'b1;
          state_nxt   = sts.up_top ? ST_WR : ST_UP_RD;
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_DN_RD: begin
        state_nxt = sts.dn_leaf ? ST_WR : ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sts.dn_move) begin
          cmd.step_dn = 1'b1;
          state_nxt   = ST_DN_RD;
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        cmd.wr_key = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.last) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/kthsel_dp.sv -----
// ---------------------------------------------------------------------------
// kthsel_dp
// Datapath: heap RAM, carried key, hole position, fill count, rank register
// and the result register.
// ---------------------------------------------------------------------------
module kthsel_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  kthsel_pkg::kthsel_cmd_t              cmd,
  output kthsel_pkg::kthsel_sts_t              sts,
  input  logic signed [kthsel_pkg::DATA_W-1:0] in_value,
  input  logic                                 in_last,
  input  logic                                 cfg_we,
  input  logic [kthsel_pkg::RANK_W-1:0]        cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [kthsel_pkg::DATA_W-1:0] out_kth_value,
  output logic                                 out_short_set
);
  import kthsel_pkg::*;

  // Keys are held with the sign bit flipped so that unsigned order is signed order.
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] top_r, top_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [RANK_W-1:0] rank_r;
  logic              last_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_short_r;

  logic [CNT_W-1:0]  k_eff;
  logic [DATA_W-1:0] in_key;
  logic [AW-1:0]     pos_m1;
  logic [AW-1:0]     parent;
  logic [CNT_W:0]    left_idx;
  logic [CNT_W:0]    right_idx;
  logic              right_ok;
  logic              pick_right;
  logic              pick_left;
  logic [AW-1:0]     raddr_a;
  logic [DATA_W-1:0] rdata_a;
  logic [DATA_W-1:0] rdata_b;
  logic              we;
  logic [DATA_W-1:0] wdata;

  // Rank in use: zero acts as one, values above the heap size saturate.
  always_comb begin
    priority if (rank_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (RANK_W'(K_MAX) < rank_r) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = CNT_W'(rank_r);
    end
  end

  assign in_key = DATA_W'(in_value) ^ SIGN_FLIP;

  // Heap index arithmetic.
  assign pos_m1    = pos_r - AW'(1);
  assign parent    = {1'b0, pos_m1[AW-1:1]};
  assign left_idx  = {{(CNT_W-AW){1'b0}}, pos_r, 1'b1};
  assign right_idx = left_idx + (CNT_W+1)'(1);
  assign right_ok  = right_idx < {1'b0, fill_r};

  // Child choice: strictly larger than the key, right only if above left too.
  assign pick_right = right_ok && (rdata_b > key_r) && (rdata_b > rdata_a);
  assign pick_left  = !pick_right && (rdata_a > key_r);

  // Status to the controller.
  always_comb begin
    sts.insert_ok  = fill_r < k_eff;
    sts.fill_zero  = fill_r == '0;
    sts.replace_ok = top_r > in_key;
    sts.up_move    = key_r > rdata_a;
    sts.up_top     = parent == '0;
    sts.dn_leaf    = left_idx >= {1'b0, fill_r};
    sts.dn_move    = pick_right || pick_left;
    sts.last       = last_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // Heap RAM write port: fill the hole with a moved entry or the key.
  always_comb begin
    we    = cmd.step_up || cmd.step_dn || cmd.wr_key;
    wdata = key_r;
    priority if (cmd.step_up) begin
      wdata = rdata_a;
    end else if (cmd.step_dn) begin
      wdata = pick_right ? rdata_b : rdata_a;
    end else begin
      wdata = key_r;
    end
  end

  assign raddr_a = cmd.rd_up ? parent : left_idx[AW-1:0];

  kthsel_ram #(
    .WIDTH (DATA_W),
    .DEPTH (K_MAX)
  ) u_heap (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (right_idx[AW-1:0]),
    .rdata_b (rdata_b)
  );

  // Next values of the working registers.
  always_comb begin
    key_nxt  = key_r;
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    top_nxt  = top_r;
    if (cmd.load) begin
      key_nxt = in_key;
      if (sts.insert_ok) begin
        pos_nxt  = fill_r[AW-1:0];
        fill_nxt = fill_r + CNT_W'(1);
      end else begin
        pos_nxt = '0;
      end
    end
    if (cmd.step_up) begin
      pos_nxt = parent;
    end
    if (cmd.step_dn) begin
      pos_nxt = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    end
    if (we && (pos_r == '0)) begin
      top_nxt = wdata;
    end
    if (cmd.out_load) begin
      fill_nxt = '0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pos_r <= pos_nxt;
    top_r <= top_nxt;
    if (cmd.load) begin
      last_r <= in_last;
    end
    if (cmd.out_load) begin
      out_value_r <= top_r ^ SIGN_FLIP;
      out_short_r <= fill_r < k_eff;
    end
  end

  // Control registers: fill count, rank and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      rank_r      <= RANK_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cfg_we) begin
        rank_r <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kth_value = $signed(out_value_r);
  assign out_short_set = out_short_r;

endmodule

// ----- rtl/kthsel_checker.sv -----
// ---------------------------------------------------------------------------
// kthsel_checker
// Port-level checks on the selection block, bound to its top level.
// ---------------------------------------------------------------------------
`include "kth_smallest_max_heap_select_core_assert.svh"

module kthsel_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [kthsel_pkg::DATA_W-1:0] out_kth_value,
  input logic                                 out_short_set
);
  import kthsel_pkg::*;

  // A stalled result stays offered.
  `KTHSEL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                      "result dropped while stalled")

  // A stalled result keeps its payload.
  `KTHSEL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready,
                      $stable(out_kth_value) && $stable(out_short_set),
                      "result changed while stalled")

  // One item at a time: taking an item closes the input for the next cycle.
  `KTHSEL_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready,
                      "input still open after taking an item")

  // A new result comes only out of the finishing step of an item.
  `KTHSEL_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(out_valid),
                      !$past(in_ready), "result appeared without an item in work")

endmodule

bind kth_smallest_max_heap_select_core kthsel_checker u_kthsel_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kth_value (out_ch.kth_value),
  .out_short_set (out_ch.short_set)
);

// ----- tb/sv/tb_kth_smallest_max_heap_select_core.sv -----
// ----------------------------------------------------------------------------
// K-th smallest selection testbench
// Streams signed values in sets through the heap selection block and checks
// every k-th smallest result and short-set flag against the expectation of a
// typed table row or a heap predictor kept in the testbench. A directed table
// walks the extremes, ties, rank saturation and rank changes within an open
// set. Random sets with rising, falling, tied and extreme values follow, over
// several ranks and idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_kth_smallest_max_heap_select_core;
  import kthsel_pkg::*;

  localparam int SETTLE_CYCLES   = 24;
  localparam int TAIL_CYCLES     = 40;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int DIRECTED_ROWS   = 33;

  typedef enum logic {ROW_ITEM, ROW_RANK} row_kind_t;

  typedef enum logic [2:0] {
    VAL_RANDOM, VAL_TIES, VAL_RISING, VAL_FALLING, VAL_EXTREME
  } value_mode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth_value;
    logic                     short_set;
  } kth_result_t;

  // One table row: an item to send, or a rank to write (held in value).
  typedef struct packed {
    row_kind_t                kind;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     typed;
    logic signed [DATA_W-1:0] want_value;
    logic                     want_short;
  } stim_row_t;

  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Rank 1 straight after reset: the set minimum, extremes first.
    '{ROW_ITEM, 32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000, 1'b0},
    '{ROW_ITEM, 32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b0},
    '{ROW_ITEM, 32'sd5,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, -32'sd3,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd7,         1'b1, 1'b1, -32'sd3,        1'b0},
    // A rank of zero acts as one.
    '{ROW_RANK, 32'sd0,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd100,       1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd50,        1'b1, 1'b1, 32'sd50,        1'b0},
    // Rank 3: a one-item set is short; then a set with a tie.
    '{ROW_RANK, 32'sd3,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd9,         1'b1, 1'b1, 32'sd9,         1'b1},
    '{ROW_ITEM, 32'sd10,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd20,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd20,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd5,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd30,        1'b1, 1'b0, 32'sd0,         1'b0},
    // A rank above the heap size saturates; a two-item set is short.
    '{ROW_RANK, 32'sd127,       1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, -32'sd1,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd0,         1'b1, 1'b1, 32'sd0,         1'b1},
    // Fill four entries, then shrink the rank within the open set.
    '{ROW_RANK, 32'sd4,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd40,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd30,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd20,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd10,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_RANK, 32'sd2,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd15,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd35,        1'b1, 1'b0, 32'sd0,         1'b0},
    // Grow the rank within an open set.
    '{ROW_ITEM, 32'sd1,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd2,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_RANK, 32'sd6,         1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sd3,         1'b1, 1'b0, 32'sd0,         1'b0},
    // Full heap size with a short set of both extremes.
    '{ROW_RANK, 32'sd64,        1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sh8000_0000, 1'b0, 1'b0, 32'sd0,         1'b0},
    '{ROW_ITEM, 32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff, 1'b1}
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RANK_W-1:0] cfg_wdata;

  kthsel_in_if  in_bus ();
  kthsel_out_if out_bus ();

  kth_smallest_max_heap_select_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Heap predictor state and the results it still owes.
  logic signed [DATA_W-1:0] heap_model [K_MAX];
  int unsigned              heap_fill;
  logic [RANK_W-1:0]        rank_reg;
  kth_result_t              kth_expected [$];
  kth_result_t              due;

  int          send_idle;
  int          recv_stall;
  int          error_count;
  int          items_sent;
  int          results_seen;
  int          quiet_cycles;
  logic [31:0] ramp;
  logic [31:0] ramp_step;

  // Clock with a period of 8.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Rank in use: zero acts as one, anything above the heap size saturates.
  function automatic int unsigned live_rank();
    if (rank_reg == '0) begin
      return 1;
    end
    if (rank_reg > K_MAX) begin
      return K_MAX;
    end
    return 32'(rank_reg);
  endfunction

  function automatic void swap_entries(input int unsigned a, input int unsigned b);
    logic signed [DATA_W-1:0] held;
    held          = heap_model[a];
    heap_model[a] = heap_model[b];
    heap_model[b] = held;
  endfunction

  // Update the heap with one value; give the result when it closes the set.
  function automatic bit absorb_value(input logic signed [DATA_W-1:0] v,
                                      input logic l, output kth_result_t res);
    int unsigned k, pos, up, left, right, pick;
    k   = live_rank();
    res = '0;
    if (heap_fill < k) begin
      pos             = heap_fill;
      heap_model[pos] = v;
      heap_fill++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (heap_model[pos] > heap_model[up]) begin
          swap_entries(pos, up);
          pos = up;
        end else begin
          break;
        end
      end
    end else if (heap_fill > 0 && heap_model[0] > v) begin
      heap_model[0] = v;
      pos           = 0;
      forever begin
        left  = 2 * pos + 1;
        right = left + 1;
        pick  = pos;
        if (left >= heap_fill) begin
          break;
        end
        if (right < heap_fill && heap_model[right] > heap_model[pos] &&
            heap_model[right] > heap_model[left]) begin
          pick = right;
        end else if (heap_model[left] > heap_model[pos]) begin
          pick = left;
        end
        if (pick == pos) begin
          break;
        end
        swap_entries(pos, pick);
        pos = pick;
      end
    end
    if (!l) begin
      return 1'b0;
    end
    res.kth_value = heap_model[0];
    res.short_set = (heap_fill < k);
    heap_fill     = 0;
    return 1'b1;
  endfunction

  // Present one item after a random gap and wait until it is taken.
  task automatic drive_item(input logic signed [DATA_W-1:0] v, input logic l,
                            output bit has, output kth_result_t res);
    while ($urandom_range(0, 99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.value <= v;
    in_bus.last  <= l;
    @(posedge clk);
    while (!in_bus.ready) begin
      @(posedge clk);
    end
    items_sent++;
    has = absorb_value(v, l, res);
  endtask

  // Write the rank once every owed result is in and the block has settled.
  task automatic set_rank(input logic [RANK_W-1:0] r);
    in_bus.valid <= 1'b0;
    while (kth_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we   <= 1'b0;
    rank_reg = r;
  endtask

  // Set length: mostly at least the rank, now and then a short set.
  function automatic int pick_set_length();
    int unsigned k;
    k = live_rank();
    if (k > 1 && $urandom_range(0, 7) == 0) begin
      return $urandom_range(1, k - 1);
    end
    return $urandom_range(k, 2 * k + 4);
  endfunction

  function automatic logic signed [DATA_W-1:0] next_value(input value_mode_t mode);
    case (mode)
      VAL_TIES: begin
        return $signed($urandom_range(0, 16)) - 8;
      end
      VAL_RISING: begin
        ramp = ramp + ramp_step;
        return ramp;
      end
      VAL_FALLING: begin
        ramp = ramp - ramp_step;
        return ramp;
      end
      VAL_EXTREME: begin
        case ($urandom_range(0, 5))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7fff_ffff;
          3: return 32'sh7fff_fffe;
          4: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  function automatic logic [RANK_W-1:0] phase_rank(input int phase);
    case (phase)
      0: return 7'd64;
      1: return 7'd1;
      2: return 7'd127;
      3: return 7'd0;
      4: return 7'd2;
      5: return RANK_W'($urandom_range(3, 63));
      6: return 7'd63;
      default: return RANK_W'($urandom_range(0, 127));
    endcase
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (kth_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d (kth_value %0d) arrived with none owed",
                                  results_seen, out_bus.kth_value));
      end else begin
        due = kth_expected.pop_front();
        if (out_bus.kth_value !== due.kth_value) begin
          report_mismatch($sformatf("result %0d kth_value %0d, predicted %0d",
                                    results_seen, out_bus.kth_value, due.kth_value));
        end
        if (out_bus.short_set !== due.short_set) begin
          report_mismatch($sformatf("result %0d short_set %b, predicted %b",
                                    results_seen, out_bus.short_set, due.short_set));
        end
      end
    end
    out_bus.ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("Timeout: no item moved for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, kth_expected.size());
    $display("FAIL");
    $finish;
  end

  // Stimulus: directed table, then random phases.
  initial begin
    stim_row_t   row;
    kth_result_t res;
    bit          has;
    int          set_left;
    value_mode_t mode;
    logic signed [DATA_W-1:0] v;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.value  = '0;
    in_bus.last   = 1'b0;
    send_idle     = 0;
    recv_stall    = 0;
    items_sent    = 0;
    heap_fill     = 0;
    rank_reg      = 7'd1;
    set_left      = 0;
    mode          = VAL_RANDOM;
    ramp          = '0;
    ramp_step     = 32'd1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed rows carry their own expectation.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_RANK) begin
        set_rank(row.value[RANK_W-1:0]);
      end else begin
        drive_item(row.value, row.last, has, res);
        if (row.typed) begin
          kth_expected.push_back('{kth_value: row.want_value, short_set: row.want_short});
        end else if (has) begin
          kth_expected.push_back(res);
        end
      end
    end

    // Random sets; a set may run on across a rank change.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_rank(phase_rank(phase));
      case (phase % 4)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle  = 84;
          recv_stall = 0;
        end
        2: begin
          send_idle  = 0;
          recv_stall = 84;
        end
        default: begin
          send_idle  = 32;
          recv_stall = 32;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (set_left <= 0) begin
          set_left  = pick_set_length();
          mode      = value_mode_t'($urandom_range(0, 4));
          ramp      = $urandom;
          ramp_step = $urandom_range(1, 4096);
        end
        v = next_value(mode);
        drive_item(v, (set_left == 1), has, res);
        if (has) begin
          kth_expected.push_back(res);
        end
        set_left--;
      end
    end

    // Drain and let any stray result show itself.
    in_bus.valid <= 1'b0;
    while (kth_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results over ranks 0 to 127,", items_sent,
             results_seen);
    $display("with rank changes inside open sets and idling on both channels.");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- kth_smallest_max_heap_select_core.f -----
+incdir+rtl
rtl/kthsel_pkg.sv
rtl/kthsel_in_if.sv
rtl/kthsel_out_if.sv
rtl/kthsel_ram.sv
rtl/kthsel_ctrl.sv
rtl/kthsel_dp.sv
rtl/kth_smallest_max_heap_select_core.sv
rtl/kthsel_checker.sv
tb/sv/tb_kth_smallest_max_heap_select_core.sv
